// File: src/trp_pkg.sv
package trp_pkg;

    localparam int ANGLE_W         = 19;
    localparam int ANGLE_FRAC_BITS = 16;
    localparam int TRIG_FRAC       = 24;
    localparam int CORDIC_STEPS    = 24;
    localparam int ANG_W           = 28;
    localparam int TRIG_W          = 28;
    localparam int PROD_W          = 2 * TRIG_W;
    // wrap, fold, one stage per micro-rotation, sign fix
    localparam int CORDIC_LAT      = CORDIC_STEPS + 3;
    localparam int ROUND_HALF      = 1 << (TRIG_FRAC - 1);

    typedef logic signed [ANG_W-1:0]  ang_t;
    typedef logic signed [TRIG_W-1:0] trig_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    localparam ang_t  PI_Q          = 28'sd52707179;
    localparam ang_t  HALF_PI_Q     = 28'sd26353589;
    localparam ang_t  TWO_PI_Q      = 28'sd105414357;
    localparam trig_t CORDIC_GAIN_Q = 28'sd10188014;
    localparam trig_t TRIG_ONE      = 28'sd16777216;

    localparam ang_t ATAN_TABLE [CORDIC_STEPS] = '{
        28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331,
        28'sd1047214,  28'sd524117,  28'sd262123,  28'sd131069,
        28'sd65536,    28'sd32768,   28'sd16384,   28'sd8192,
        28'sd4096,     28'sd2048,    28'sd1024,    28'sd512,
        28'sd256,      28'sd128,     28'sd64,      28'sd32,
        28'sd16,       28'sd8,       28'sd4,       28'sd2
    };

    // register index, taken from paddr[2]
    localparam logic REG_AXIS_TILT = 1'b0;

    // Q24 product rounded to nearest, ties up
    function automatic trig_t qmul(input trig_t a, input trig_t b);
        prod_t p;
        p = a * b;
        p = p + prod_t'(ROUND_HALF);
        return trig_t'(p >>> TRIG_FRAC);
    endfunction

    function automatic trig_t qround(input logic signed [PROD_W:0] v);
        logic signed [PROD_W:0] r;
        r = v + (PROD_W + 1)'(ROUND_HALF);
        return trig_t'(r >>> TRIG_FRAC);
    endfunction

endpackage

// File: src/trp_in_if.sv
interface trp_in_if #(parameter int COORD_WIDTH = 32);
    logic                                valid;
    logic                                ready;
    logic signed [COORD_WIDTH-1:0]       point_x;
    logic signed [COORD_WIDTH-1:0]       point_y;
    logic signed [COORD_WIDTH-1:0]       point_z;
    logic signed [trp_pkg::ANGLE_W-1:0]  tilt_angle;

    modport source (output valid, point_x, point_y, point_z, tilt_angle, input ready);
    modport sink   (input valid, point_x, point_y, point_z, tilt_angle, output ready);
endinterface

// File: src/trp_out_if.sv
interface trp_out_if #(parameter int COORD_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] rotated_x;
    logic signed [COORD_WIDTH-1:0] rotated_y;
    logic signed [COORD_WIDTH-1:0] rotated_z;
    logic                          saturated;

    modport source (output valid, rotated_x, rotated_y, rotated_z, saturated, input ready);
    modport sink   (input valid, rotated_x, rotated_y, rotated_z, saturated, output ready);
endinterface

// File: src/trp_cordic.sv
module trp_cordic (
    input  logic                                 clk,
    input  logic [trp_pkg::CORDIC_LAT-1:0]       stage_en,
    input  logic signed [trp_pkg::ANGLE_W-1:0]   angle,
    output trp_pkg::trig_t                       cos_q,
    output trp_pkg::trig_t                       sin_q
);
    import trp_pkg::*;

    ang_t  scaled;
    ang_t  wrap_next;
    ang_t  wrap_reg;
    ang_t  fold_next;
    logic  neg_next;
    ang_t  fold_reg;
    logic  neg_reg;
    trig_t x_reg [CORDIC_STEPS];
    trig_t y_reg [CORDIC_STEPS];
    ang_t  a_reg [CORDIC_STEPS];
    logic  n_reg [CORDIC_STEPS];
    trig_t cos_reg;
    trig_t sin_reg;

    assign scaled = ang_t'(angle) <<< (TRIG_FRAC - ANGLE_FRAC_BITS);

    always_comb
    begin
        if (scaled > PI_Q)
            wrap_next = scaled - TWO_PI_Q;
        else if (scaled < -PI_Q)
            wrap_next = scaled + TWO_PI_Q;
        else
            wrap_next = scaled;
    end

    always_comb
    begin
        neg_next = 1'b1;
        if (wrap_reg > HALF_PI_Q)
            fold_next = wrap_reg - PI_Q;
        else if (wrap_reg < -HALF_PI_Q)
            fold_next = wrap_reg + PI_Q;
        else
        begin
            fold_next = wrap_reg;
            neg_next  = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
            wrap_reg <= wrap_next;
        if (stage_en[1])
        begin
            fold_reg <= fold_next;
            neg_reg  <= neg_next;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        trig_t xi;
        trig_t yi;
        ang_t  ai;
        logic  ni;

        if (i == 0)
        begin : g_first
            assign xi = CORDIC_GAIN_Q;
            assign yi = '0;
            assign ai = fold_reg;
            assign ni = neg_reg;
        end
        else
        begin : g_rest
            assign xi = x_reg[i-1];
            assign yi = y_reg[i-1];
            assign ai = a_reg[i-1];
            assign ni = n_reg[i-1];
        end

        always_ff @(posedge clk)
        begin
            if (stage_en[i+2])
            begin
                n_reg[i] <= ni;
                if (ai >= 0)
                begin
                    x_reg[i] <= xi - (yi >>> i);
                    y_reg[i] <= yi + (xi >>> i);
                    a_reg[i] <= ai - ATAN_TABLE[i];
                end
                else
                begin
                    x_reg[i] <= xi + (yi >>> i);
                    y_reg[i] <= yi - (xi >>> i);
                    a_reg[i] <= ai + ATAN_TABLE[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[CORDIC_LAT-1])
        begin
            cos_reg <= n_reg[CORDIC_STEPS-1] ? -x_reg[CORDIC_STEPS-1] : x_reg[CORDIC_STEPS-1];
            sin_reg <= n_reg[CORDIC_STEPS-1] ? -y_reg[CORDIC_STEPS-1] : y_reg[CORDIC_STEPS-1];
        end
    end

    assign cos_q = cos_reg;
    assign sin_q = sin_reg;

endmodule

// File: src/tilted_axis_point_rotator.sv
// channel   dir  payload                                      beat
// in_ch     in   point_x/y/z (Q16.16), tilt_angle (Q.16 rad)  valid & ready
// out_ch    out  rotated_x/y/z (Q16.16), saturated            valid & ready
// apb       in   axis_tilt_angle at byte address 0            psel & penable & pwrite
//
// One beat per cycle in and out while the output is not stalled. Stages: 1 input
// stage, 27 in the two parallel CORDIC pipelines, 4 for the matrix, 3 for the dot
// products and clamp. Each stage holds while the one after it is full and stalled;
// empty stages fill, so bubbles close up behind a stalled output. Reset clears
// valid bits and the tilt register only.
module tilted_axis_point_rotator #(
    parameter int COORD_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    trp_in_if.sink      in_ch,
    trp_out_if.source   out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import trp_pkg::*;

    localparam int NS     = CORDIC_LAT + 8;
    localparam int ST_M1  = CORDIC_LAT + 1;
    localparam int ST_M2  = CORDIC_LAT + 2;
    localparam int ST_M3  = CORDIC_LAT + 3;
    localparam int ST_M4  = CORDIC_LAT + 4;
    localparam int ST_D1  = CORDIC_LAT + 5;
    localparam int ST_D2  = CORDIC_LAT + 6;
    localparam int ST_OUT = NS - 1;
    localparam int PW     = COORD_WIDTH + TRIG_W;
    localparam int SUMW   = PW + 2;
    localparam int RW     = SUMW - TRIG_FRAC;

    localparam logic signed [RW-1:0] OUT_MAX =
        {{(RW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [RW-1:0] OUT_MIN =
        {{(RW-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic signed [COORD_WIDTH-1:0] z;
        logic                          phi_zero;
    } pt_t;

    logic [NS-1:0]        valid_reg;
    logic [NS-1:0]        stage_en;
    logic [ANGLE_W-1:0]   axis_tilt_reg;
    logic signed [ANGLE_W-1:0] theta_reg;
    logic signed [ANGLE_W-1:0] phi_reg;
    pt_t                  pt_reg [ST_M4+1];
    trig_t                c_q, s_q, cp_q, sp_q;

    // matrix stages
    trig_t c1_reg, s1_reg, cp1_reg, sp1_reg, ta_reg, tb_reg, saz1_reg, say1_reg;
    trig_t c2_reg, s2_reg, cp2_reg, sp2_reg, saz2_reg, say2_reg, r11_reg, r12_reg, r22_reg;
    trig_t c3_reg, s3_reg, saz3_reg, say3_reg;
    prod_t pa_reg [3];
    prod_t pb_reg [3];
    prod_t pc_reg [3];
    prod_t pd_reg [3];
    trig_t r_i1 [3];
    trig_t r_i2 [3];
    trig_t mat_next [3][3];
    trig_t mat_reg  [3][3];

    // dot product stages
    logic signed [PW-1:0]  prod_reg [3][3];
    logic signed [RW-1:0]  dot_reg  [3];
    logic signed [COORD_WIDTH-1:0] rx_reg, ry_reg, rz_reg;
    logic                  sat_reg;

    function automatic logic over(input logic signed [RW-1:0] v);
        return (v > OUT_MAX) || (v < OUT_MIN);
    endfunction

    function automatic logic signed [COORD_WIDTH-1:0] clamp(input logic signed [RW-1:0] v);
        logic signed [RW-1:0] r;
        if (v > OUT_MAX)
            r = OUT_MAX;
        else if (v < OUT_MIN)
            r = OUT_MIN;
        else
            r = v;
        return r[COORD_WIDTH-1:0];
    endfunction

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            axis_tilt_reg <= '0;
        else if (psel && penable && pwrite && paddr[2] == REG_AXIS_TILT)
            axis_tilt_reg <= pwdata[ANGLE_W-1:0];
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_AXIS_TILT) ? {{(32-ANGLE_W){1'b0}}, axis_tilt_reg} : '0;

    // ---------------- pipeline control ----------------
    always_comb
    begin
        stage_en[NS-1] = !valid_reg[NS-1] || out_ch.ready;
        for (int k = NS - 2; k >= 0; k--)
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            if (stage_en[0])
                valid_reg[0] <= in_ch.valid;
            for (int k = 1; k < NS; k++)
                if (stage_en[k])
                    valid_reg[k] <= valid_reg[k-1];
        end
    end

    assign in_ch.ready = stage_en[0];

    // ---------------- input stage and point delay line ----------------
    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            theta_reg          <= in_ch.tilt_angle;
            phi_reg            <= axis_tilt_reg;
            pt_reg[0].x        <= in_ch.point_x;
            pt_reg[0].y        <= in_ch.point_y;
            pt_reg[0].z        <= in_ch.point_z;
            pt_reg[0].phi_zero <= (axis_tilt_reg == '0);
        end
        for (int k = 1; k <= ST_M4; k++)
            if (stage_en[k])
                pt_reg[k] <= pt_reg[k-1];
    end

    trp_cordic u_cordic_theta (
        .clk      (clk),
        .stage_en (stage_en[CORDIC_LAT:1]),
        .angle    (theta_reg),
        .cos_q    (c_q),
        .sin_q    (s_q)
    );

    trp_cordic u_cordic_phi (
        .clk      (clk),
        .stage_en (stage_en[CORDIC_LAT:1]),
        .angle    (phi_reg),
        .cos_q    (cp_q),
        .sin_q    (sp_q)
    );

    // ---------------- Rodrigues matrix, merged with the x turn ----------------
    always_comb
    begin
        r_i1[0] = -saz2_reg;
        r_i2[0] = say2_reg;
        r_i1[1] = r11_reg;
        r_i2[1] = r12_reg;
        r_i1[2] = r12_reg;
        r_i2[2] = r22_reg;
    end

    always_comb
    begin
        if (pt_reg[ST_M3].phi_zero)
        begin
            mat_next[0][0] = c3_reg;
            mat_next[0][1] = '0;
            mat_next[0][2] = -s3_reg;
            mat_next[1][0] = '0;
            mat_next[1][1] = TRIG_ONE;
            mat_next[1][2] = '0;
            mat_next[2][0] = s3_reg;
            mat_next[2][1] = '0;
            mat_next[2][2] = c3_reg;
        end
        else
        begin
            mat_next[0][0] = c3_reg;
            mat_next[1][0] = saz3_reg;
            mat_next[2][0] = -say3_reg;
            for (int i = 0; i < 3; i++)
            begin
                mat_next[i][1] = qround((PROD_W + 1)'(pa_reg[i]) - (PROD_W + 1)'(pb_reg[i]));
                mat_next[i][2] = qround((PROD_W + 1)'(pc_reg[i]) + (PROD_W + 1)'(pd_reg[i]));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[ST_M1])
        begin
            c1_reg   <= c_q;
            s1_reg   <= s_q;
            cp1_reg  <= cp_q;
            sp1_reg  <= sp_q;
            ta_reg   <= qmul(TRIG_ONE - c_q, cp_q);
            tb_reg   <= qmul(TRIG_ONE - c_q, -sp_q);
            saz1_reg <= qmul(s_q, -sp_q);
            say1_reg <= qmul(s_q, cp_q);
        end
        if (stage_en[ST_M2])
        begin
            c2_reg   <= c1_reg;
            s2_reg   <= s1_reg;
            cp2_reg  <= cp1_reg;
            sp2_reg  <= sp1_reg;
            saz2_reg <= saz1_reg;
            say2_reg <= say1_reg;
            r11_reg  <= c1_reg + qmul(ta_reg, cp1_reg);
            r12_reg  <= qmul(ta_reg, -sp1_reg);
            r22_reg  <= c1_reg + qmul(tb_reg, -sp1_reg);
        end
        if (stage_en[ST_M3])
        begin
            c3_reg   <= c2_reg;
            s3_reg   <= s2_reg;
            saz3_reg <= saz2_reg;
            say3_reg <= say2_reg;
            for (int i = 0; i < 3; i++)
            begin
                pa_reg[i] <= r_i1[i] * cp2_reg;
                pb_reg[i] <= r_i2[i] * sp2_reg;
                pc_reg[i] <= r_i1[i] * sp2_reg;
                pd_reg[i] <= r_i2[i] * cp2_reg;
            end
        end
        if (stage_en[ST_M4])
            mat_reg <= mat_next;
    end

    // ---------------- dot products, rounding, clamp ----------------
    always_ff @(posedge clk)
    begin
        if (stage_en[ST_D1])
        begin
            for (int i = 0; i < 3; i++)
            begin
                prod_reg[i][0] <= pt_reg[ST_M4].x * mat_reg[i][0];
                prod_reg[i][1] <= pt_reg[ST_M4].y * mat_reg[i][1];
                prod_reg[i][2] <= pt_reg[ST_M4].z * mat_reg[i][2];
            end
        end
        if (stage_en[ST_D2])
        begin
            for (int i = 0; i < 3; i++)
                dot_reg[i] <= RW'((SUMW'(prod_reg[i][0]) + SUMW'(prod_reg[i][1])
                                   + SUMW'(prod_reg[i][2]) + SUMW'(ROUND_HALF)) >>> TRIG_FRAC);
        end
        if (stage_en[ST_OUT])
        begin
            rx_reg  <= clamp(dot_reg[0]);
            ry_reg  <= clamp(dot_reg[1]);
            rz_reg  <= clamp(dot_reg[2]);
            sat_reg <= over(dot_reg[0]) || over(dot_reg[1]) || over(dot_reg[2]);
        end
    end

    assign out_ch.valid     = valid_reg[ST_OUT];
    assign out_ch.rotated_x = rx_reg;
    assign out_ch.rotated_y = ry_reg;
    assign out_ch.rotated_z = rz_reg;
    assign out_ch.saturated = sat_reg;

endmodule
